// ===== rtl/ugnq_pkg.sv =====
// ----------------------------------------------------------------------------
// ugnq_pkg
// Shared constants, codes and types of the uniform grid neighbor query block.
// ----------------------------------------------------------------------------
package ugnq_pkg;

    // grid geometry
    localparam int GRID_X     = 16;
    localparam int GRID_Z     = 16;
    localparam int CELL_SLOTS = 4;
    localparam int NUM_CELLS  = GRID_X * GRID_Z;
    localparam int NUM_SLOTS  = NUM_CELLS * CELL_SLOTS;

    localparam int CX_W    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int CZ_W    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int CELL_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FILL_W  = $clog2(CELL_SLOTS + 1);

    // field widths
    localparam int POS_W  = 20;
    localparam int ID_W   = 8;
    localparam int CSZ_W  = 16;
    localparam int SQ_W   = 2 * POS_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int SLOT_W = ID_W + 3 * POS_W;

    // request codes
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // register indexes
    localparam logic REG_CELL_X = 1'b0;
    localparam logic REG_CELL_Z = 1'b1;

    // stored slot word
    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_slot;

    // sequencer to store requests
    typedef struct packed {
        logic               clear;
        logic               fill_rd;
        logic               fill_we;
        logic [CELL_W-1:0]  fill_addr;
        logic [FILL_W-1:0]  fill_wdata;
        logic               slot_rd;
        logic               slot_we;
        logic [SLOT_AW-1:0] slot_addr;
        t_slot              slot_wdata;
    } t_store_req;

    // magnitude of a difference of two signed positions
    function automatic logic [POS_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                  logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic [POS_W:0]        m;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        m = d[POS_W] ? (~d + 1'b1) : d;
        return m[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/ugnq_if.sv =====
// ----------------------------------------------------------------------------
// ugnq_if
// Request and result channels of the grid neighbor query block.
// ----------------------------------------------------------------------------
interface ugnq_req_if;
    import ugnq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic [ID_W-1:0]         actor_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [POS_W-1:0]        query_radius;

    modport source (output valid, req_type, actor_id, pos_x, pos_y, pos_z, query_radius,
                    input ready);
    modport sink (input valid, req_type, actor_id, pos_x, pos_y, pos_z, query_radius,
                  output ready);
endinterface

interface ugnq_res_if;
    import ugnq_pkg::*;
    logic            valid;
    logic            ready;
    logic [1:0]      status;
    logic            match_valid;
    logic [ID_W-1:0] found_id;
    logic            last;

    modport source (output valid, status, match_valid, found_id, last, input ready);
    modport sink (input valid, status, match_valid, found_id, last, output ready);
endinterface

// ===== rtl/uniform_grid_neighbor_query.sv =====
// ----------------------------------------------------------------------------
// uniform_grid_neighbor_query
// Uniform x/z grid of actor buckets with clear, insert and radius query.
//
//  channel  dir  handshake        payload
//  i_req    in   valid/ready      req_type actor_id pos_x pos_y pos_z query_radius
//  o_res    out  valid/ready      status match_valid found_id last
//  apb      in   psel/penable     paddr pwdata (cell_size_x at 0, cell_size_z at 4)
//
// One item at a time. Clear and unused codes answer directly; insert and query
// first wait on the bit-serial cell dividers. Insert then reads and writes the
// bucket fill, and query walks each visited bucket, reading every stored slot
// and passing it through the registered distance check. The sequencer returns
// to idle as the last result loads and takes the next item from there. A match
// is held one step so that the final one carries last. Synchronous reset empties
// all buckets at once through valid bits. A stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module uniform_grid_neighbor_query (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ugnq_req_if.sink                    i_req,
    ugnq_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ugnq_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_EMIT    = 12'b000000000010,
        S_DIV     = 12'b000000000100,
        S_INS_RD  = 12'b000000001000,
        S_INS_WR  = 12'b000000010000,
        S_Q_START = 12'b000000100000,
        S_Q_FILL  = 12'b000001000000,
        S_Q_FWAIT = 12'b000010000000,
        S_Q_SLOT  = 12'b000100000000,
        S_Q_SQ    = 12'b001000000000,
        S_Q_CMP   = 12'b010000000000,
        S_Q_END   = 12'b100000000000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [CSZ_W-1:0] r_csx;
    logic [CSZ_W-1:0] r_csz;

    // latched item
    logic [1:0]              r_type;
    t_slot                   r_item;
    logic [POS_W-1:0]        r_rad;
    logic [SQ_W-1:0]         r_r2;

    // walk state
    logic [CX_W-1:0]   r_cx;
    logic [CZ_W-1:0]   r_cz;
    logic [CX_W-1:0]   r_x;
    logic [CZ_W-1:0]   r_z;
    logic [FILL_W-1:0] r_s;
    logic [FILL_W-1:0] r_f;
    logic [1:0]        r_st;
    logic [SQ_W-1:0]   r_sq0;
    logic [SQ_W-1:0]   r_sq1;
    logic [SQ_W-1:0]   r_sq2;
    logic [ID_W-1:0]   r_cand;
    logic              r_have;
    logic [ID_W-1:0]   r_pend;

    // result register
    logic            r_ov;
    logic [1:0]      r_ost;
    logic            r_omv;
    logic [ID_W-1:0] r_oid;
    logic            r_olast;

    logic             out_free;
    logic             res_load;
    logic             div_start;
    logic             div_done_x;
    logic             div_done_z;
    logic [POS_W-1:0] quo_x;
    logic [POS_W-1:0] quo_z;
    logic [CX_W-1:0]  cx_cl;
    logic [CZ_W-1:0]  cz_cl;
    logic [CX_W-1:0]  x0;
    logic [CX_W-1:0]  x1;
    logic [CZ_W-1:0]  z0;
    logic [CZ_W-1:0]  z1;
    logic [CELL_W-1:0] cell_idx;
    logic [FILL_W-1:0] fill;
    t_slot             slot;
    logic [SUM_W-1:0]  d2;
    logic              hit;
    logic              accept;
    t_store_req        st_req;

    // apb configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CELL_Z) ? {16'b0, r_csz} : {16'b0, r_csx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csx <= CSZ_W'(2560);
            r_csz <= CSZ_W'(2560);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_CELL_X) begin
                r_csx <= pwdata[CSZ_W-1:0];
            end else begin
                r_csz <= pwdata[CSZ_W-1:0];
            end
        end
    end

    // cell dividers, negative positions map to cell zero
    assign div_start = accept && (i_req.req_type == REQ_INSERT ||
                                  i_req.req_type == REQ_QUERY);

    ugnq_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.pos_x[POS_W-1] ? '0 : i_req.pos_x),
        .i_divisor  (r_csx),
        .o_done     (div_done_x),
        .o_quo      (quo_x)
    );

    ugnq_div u_div_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.pos_z[POS_W-1] ? '0 : i_req.pos_z),
        .i_divisor  (r_csz),
        .o_done     (div_done_z),
        .o_quo      (quo_z)
    );

    // clamp to grid and neighborhood bounds
    assign cx_cl = (quo_x > POS_W'(GRID_X - 1)) ? CX_W'(GRID_X - 1) : quo_x[CX_W-1:0];
    assign cz_cl = (quo_z > POS_W'(GRID_Z - 1)) ? CZ_W'(GRID_Z - 1) : quo_z[CZ_W-1:0];
    assign x0 = (r_cx > '0) ? r_cx - 1'b1 : '0;
    assign x1 = (r_cx < CX_W'(GRID_X - 1)) ? r_cx + 1'b1 : r_cx;
    assign z0 = (r_cz > '0) ? r_cz - 1'b1 : '0;
    assign z1 = (r_cz < CZ_W'(GRID_Z - 1)) ? r_cz + 1'b1 : r_cz;
    assign cell_idx = CELL_W'(CELL_W'(r_z) * CELL_W'(GRID_X) + CELL_W'(r_x));

    // store requests
    always_comb begin
        st_req            = '0;
        st_req.clear      = accept && (i_req.req_type == REQ_CLEAR);
        st_req.fill_addr  = cell_idx;
        st_req.fill_rd    = (r_state == S_INS_RD) || (r_state == S_Q_FILL);
        st_req.fill_we    = (r_state == S_INS_WR) && (fill < FILL_W'(CELL_SLOTS));
        st_req.fill_wdata = fill + 1'b1;
        st_req.slot_we    = st_req.fill_we;
        st_req.slot_rd    = (r_state == S_Q_SLOT) && (r_s < r_f);
        st_req.slot_addr  = SLOT_AW'(SLOT_AW'(cell_idx) * SLOT_AW'(CELL_SLOTS) +
                            SLOT_AW'((r_state == S_INS_WR) ? fill : r_s));
        st_req.slot_wdata = r_item;
    end

    ugnq_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (st_req),
        .o_fill  (fill),
        .o_slot  (slot)
    );

    // distance check against the squared radius
    assign d2  = SUM_W'(r_sq0) + SUM_W'(r_sq1) + SUM_W'(r_sq2);
    assign hit = d2 <= SUM_W'(r_r2);

    assign out_free    = !r_ov || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);

    // result register loads when a result goes out this cycle
    assign res_load = out_free && ((r_state == S_EMIT) || (r_state == S_Q_END) ||
                                   (r_state == S_Q_CMP && hit && r_have));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (res_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_type <= i_req.req_type;
                        r_item <= '{id: i_req.actor_id, x: i_req.pos_x,
                                    y: i_req.pos_y, z: i_req.pos_z};
                        r_rad  <= i_req.query_radius;
                        r_st   <= ST_OK;
                        r_state <= div_start ? S_DIV : S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ost   <= r_st;
                        r_omv   <= 1'b0;
                        r_oid   <= '0;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_r2 <= r_rad * r_rad;
                    if (div_done_x && div_done_z) begin
                        r_cx <= cx_cl;
                        r_cz <= cz_cl;
                        r_x  <= cx_cl;
                        r_z  <= cz_cl;
                        r_state <= (r_type == REQ_INSERT) ? S_INS_RD : S_Q_START;
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    r_st    <= (fill < FILL_W'(CELL_SLOTS)) ? ST_OK : ST_FULL;
                    r_state <= S_EMIT;
                end
                S_Q_START: begin
                    r_x     <= x0;
                    r_z     <= z0;
                    r_have  <= 1'b0;
                    r_state <= S_Q_FILL;
                end
                S_Q_FILL: begin
                    r_s     <= '0;
                    r_state <= S_Q_FWAIT;
                end
                S_Q_FWAIT: begin
                    r_f     <= (fill > FILL_W'(CELL_SLOTS)) ? FILL_W'(CELL_SLOTS) : fill;
                    r_state <= S_Q_SLOT;
                end
                S_Q_SLOT: begin
                    priority if (r_s < r_f) begin
                        r_state <= S_Q_SQ;
                    end else if (r_x < x1) begin
                        r_x     <= r_x + 1'b1;
                        r_state <= S_Q_FILL;
                    end else if (r_z < z1) begin
                        r_z     <= r_z + 1'b1;
                        r_x     <= x0;
                        r_state <= S_Q_FILL;
                    end else begin
                        r_state <= S_Q_END;
                    end
                end
                S_Q_SQ: begin
                    r_sq0   <= abs_diff(slot.x, r_item.x) * abs_diff(slot.x, r_item.x);
                    r_sq1   <= abs_diff(slot.y, r_item.y) * abs_diff(slot.y, r_item.y);
                    r_sq2   <= abs_diff(slot.z, r_item.z) * abs_diff(slot.z, r_item.z);
                    r_cand  <= slot.id;
                    r_state <= S_Q_CMP;
                end
                S_Q_CMP: begin
                    // a new match releases the held one without last
                    priority if (!hit) begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_Q_SLOT;
                    end else if (!r_have) begin
                        r_have  <= 1'b1;
                        r_pend  <= r_cand;
                        r_s     <= r_s + 1'b1;
                        r_state <= S_Q_SLOT;
                    end else if (out_free) begin
                        r_ost   <= ST_OK;
                        r_omv   <= 1'b1;
                        r_oid   <= r_pend;
                        r_olast <= 1'b0;
                        r_pend  <= r_cand;
                        r_s     <= r_s + 1'b1;
                        r_state <= S_Q_SLOT;
                    end
                end
                S_Q_END: begin
                    if (out_free) begin
                        r_ost   <= r_have ? ST_OK : ST_NONE;
                        r_omv   <= r_have;
                        r_oid   <= r_have ? r_pend : '0;
                        r_olast <= 1'b1;
                        r_have  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.status      = r_ost;
    assign o_res.match_valid = r_omv;
    assign o_res.found_id    = r_oid;
    assign o_res.last        = r_olast;

    // checks
    a_match_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_omv |-> r_ost == ST_OK)
        else $error("match result with non-ok status");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && (r_ost == ST_NONE || r_ost == ST_FULL) |-> r_olast && !r_omv)
        else $error("error status without last");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_Q_SLOT |-> r_f <= FILL_W'(CELL_SLOTS) && r_s <= r_f)
        else $error("slot walk past bucket fill");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_Q_CMP && hit && r_have && !out_free |=> r_state == S_Q_CMP)
        else $error("match dropped while result stalled");

endmodule

// ===== rtl/ugnq_div.sv =====
// ----------------------------------------------------------------------------
// ugnq_div
// Restoring divider, one quotient bit per cycle, for the cell index.
// ----------------------------------------------------------------------------
module ugnq_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ugnq_pkg::POS_W-1:0]    i_dividend,
    input  logic [ugnq_pkg::CSZ_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [ugnq_pkg::POS_W-1:0]    o_quo
);
    import ugnq_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic [CSZ_W-1:0] r_div;
    logic [CSZ_W-1:0] r_rem;
    logic [POS_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [CSZ_W:0]   sh;
    logic [CSZ_W:0]   diff;
    logic             ge;

    // one restoring step
    assign sh   = {r_rem, r_quo[POS_W-1]};
    assign ge   = sh >= {1'b0, r_div};
    assign diff = sh - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(POS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, zero divisor counts as one
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= (i_divisor == '0) ? CSZ_W'(1) : i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[CSZ_W-1:0] : sh[CSZ_W-1:0];
            r_quo <= {r_quo[POS_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/ugnq_store.sv =====
// ----------------------------------------------------------------------------
// ugnq_store
// Bucket fill memory with per-bucket valid bits, and the slot memory.
// ----------------------------------------------------------------------------
module ugnq_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ugnq_pkg::t_store_req          i_req,
    output logic [ugnq_pkg::FILL_W-1:0]   o_fill,
    output ugnq_pkg::t_slot               o_slot
);
    import ugnq_pkg::*;

    logic [FILL_W-1:0] fill_mem [NUM_CELLS];
    t_slot             slot_mem [NUM_SLOTS];
    logic [NUM_CELLS-1:0] r_fvalid;
    logic [FILL_W-1:0] r_fill_q;
    logic              r_fvalid_q;
    t_slot             r_slot_q;

    // valid bits, clear empties every bucket at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= '0;
        end else if (i_req.clear) begin
            r_fvalid <= '0;
        end else if (i_req.fill_we) begin
            r_fvalid[i_req.fill_addr] <= 1'b1;
        end
    end

    // fill memory
    always_ff @(posedge i_clk) begin
        if (i_req.fill_we) begin
            fill_mem[i_req.fill_addr] <= i_req.fill_wdata;
        end
        if (i_req.fill_rd) begin
            r_fill_q   <= fill_mem[i_req.fill_addr];
            r_fvalid_q <= r_fvalid[i_req.fill_addr];
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (i_req.slot_we) begin
            slot_mem[i_req.slot_addr] <= i_req.slot_wdata;
        end
        if (i_req.slot_rd) begin
            r_slot_q <= slot_mem[i_req.slot_addr];
        end
    end

    assign o_fill = r_fvalid_q ? r_fill_q : '0;
    assign o_slot = r_slot_q;

endmodule

// ===== test/tb_uniform_grid_neighbor_query.sv =====
// ----------------------------------------------------------------------------
// tb_uniform_grid_neighbor_query
// Self-checking bench for the grid neighbor query block: a local grid model
// predicts every result, directed and random requests and handshake gaps drive the block.
// ----------------------------------------------------------------------------
module tb_uniform_grid_neighbor_query;
    import ugnq_pkg::*;

    // unused request code, answered with a plain ok
    localparam logic [1:0] REQ_RSVD = 2'd3;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [ID_W-1:0]         actor_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [POS_W-1:0]        query_radius;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic            match_valid;
        logic [ID_W-1:0] found_id;
        logic            last;
    } t_res;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ugnq_req_if req_ch ();
    ugnq_res_if res_ch ();

    uniform_grid_neighbor_query i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // grid model state
    logic [CSZ_W-1:0]        csz_x, csz_z;
    int                      fill_cnt [NUM_CELLS];
    logic [ID_W-1:0]         ids [NUM_CELLS][CELL_SLOTS];
    logic signed [POS_W-1:0] px_s [NUM_CELLS][CELL_SLOTS];
    logic signed [POS_W-1:0] py_s [NUM_CELLS][CELL_SLOTS];
    logic signed [POS_W-1:0] pz_s [NUM_CELLS][CELL_SLOTS];

    t_req pending_reqs [$];
    t_res expected_res [$];
    int   mismatches;
    int   idle_cycles;
    int   hold_off;
    bit   sender_pause;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // append one request to the pending list
    task automatic queue_req(t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // cell index along one axis, clamped into the grid
    function automatic int axis_cell(logic signed [POS_W-1:0] p, logic [CSZ_W-1:0] sz,
                                     int count);
        int unsigned q;
        int unsigned d;
        d = (sz == 0) ? 1 : sz;
        if (p < 0) return 0;
        q = int'(p) / d;
        return (q > count - 1) ? count - 1 : q;
    endfunction

    function automatic longint unsigned sq_dist(logic signed [POS_W-1:0] a,
                                                logic signed [POS_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return d * d;
    endfunction

    // apply one request to the grid model and queue its results
    task automatic grid_apply(t_req r);
        int cx, cz, c, f, n;
        longint unsigned r2, d2;
        t_res e;
        cx = axis_cell(r.pos_x, csz_x, GRID_X);
        cz = axis_cell(r.pos_z, csz_z, GRID_Z);
        e = '{status: ST_OK, match_valid: 1'b0, found_id: '0, last: 1'b1};
        if (r.req_type == REQ_CLEAR) begin
            foreach (fill_cnt[i]) fill_cnt[i] = 0;
        end else if (r.req_type == REQ_INSERT) begin
            c = cz * GRID_X + cx;
            f = fill_cnt[c];
            if (f >= CELL_SLOTS) begin
                e.status = ST_FULL;
            end else begin
                ids[c][f]  = r.actor_id;
                px_s[c][f] = r.pos_x;
                py_s[c][f] = r.pos_y;
                pz_s[c][f] = r.pos_z;
                fill_cnt[c] = f + 1;
            end
        end else if (r.req_type == REQ_QUERY) begin
            r2 = longint'(r.query_radius) * longint'(r.query_radius);
            n = 0;
            for (int z = (cz > 0 ? cz - 1 : 0); z <= (cz < GRID_Z - 1 ? cz + 1 : GRID_Z - 1);
                 z++) begin
                for (int x = (cx > 0 ? cx - 1 : 0);
                     x <= (cx < GRID_X - 1 ? cx + 1 : GRID_X - 1); x++) begin
                    c = z * GRID_X + x;
                    for (int s = 0; s < fill_cnt[c]; s++) begin
                        d2 = sq_dist(px_s[c][s], r.pos_x) + sq_dist(py_s[c][s], r.pos_y)
                           + sq_dist(pz_s[c][s], r.pos_z);
                        if (d2 <= r2) begin
                            expected_res.insert(expected_res.size(),
                                                '{status: ST_OK, match_valid: 1'b1,
                                                  found_id: ids[c][s], last: 1'b0});
                            n++;
                        end
                    end
                end
            end
            if (n > 0) begin
                expected_res[$].last = 1'b1;
                return;
            end
            e.status = ST_NONE;
        end
        expected_res.insert(expected_res.size(), e);
    endtask

    task automatic report(string what, t_res got, t_res exp);
        $display("error %0t: %s got st=%0d mv=%0d id=%0d last=%0d",
                 $realtime, what, got.status, got.match_valid, got.found_id, got.last,
                 " exp st=%0d mv=%0d id=%0d last=%0d",
                 exp.status, exp.match_valid, exp.found_id, exp.last);
        mismatches++;
    endtask

    // driver: random gap before each item, optional pause until drained
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap <= 0;
        end else if (req_ch.valid && !req_ch.ready) begin
            // hold current item
        end else begin
            if (req_ch.valid) begin
                grid_apply(pending_reqs.pop_front());
                send_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
                req_ch.valid <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0 && !sender_pause) begin
                req_ch.valid        <= 1'b1;
                req_ch.req_type     <= pending_reqs[0].req_type;
                req_ch.actor_id     <= pending_reqs[0].actor_id;
                req_ch.pos_x        <= pending_reqs[0].pos_x;
                req_ch.pos_y        <= pending_reqs[0].pos_y;
                req_ch.pos_z        <= pending_reqs[0].pos_z;
                req_ch.query_radius <= pending_reqs[0].query_radius;
            end
        end
    end

    // monitor: random stall per result, long hold-off on request
    int recv_gap;
    always @(posedge i_clk) begin
        t_res got;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = '{status: res_ch.status, match_valid: res_ch.match_valid,
                        found_id: res_ch.found_id, last: res_ch.last};
                if (expected_res.size() == 0) report("unexpected result", got, got);
                else if (got != expected_res[0]) report("wrong result", got, expected_res.pop_front());
                else void'(expected_res.pop_front());
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                res_ch.ready <= 1'b0;
            end else if (res_ch.valid && res_ch.ready) begin
                recv_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
                res_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake or register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("uniform_grid_neighbor_query: mismatch");
            $finish;
        end
    end

    task automatic reg_write(logic reg_idx, logic [CSZ_W-1:0] val);
        paddr  <= {reg_idx, 2'b00};
        pwdata <= 32'(val);
        pwrite <= 1'b1;
        psel   <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_CELL_X) csz_x = val; else csz_z = val;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_req mk(logic [1:0] t, int x, int y, int z, int rad);
        t_req r;
        r.req_type = t;
        r.actor_id = ID_W'($urandom_range(0, 255));
        r.pos_x = POS_W'(x);
        r.pos_y = POS_W'(y);
        r.pos_z = POS_W'(z);
        r.query_radius = POS_W'(rad);
        return r;
    endfunction

    // random position near a cluster so queries find neighbors
    function automatic int near(int base, int spread);
        return base + $urandom_range(0, 2 * spread) - spread;
    endfunction

    task automatic random_phase(int count);
        int bx, bz;
        t_req r;
        logic [1:0] t;
        bx = $urandom_range(0, 16 * csz_x);
        bz = $urandom_range(0, 16 * csz_z);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0:       t = REQ_CLEAR;
                1:       t = REQ_RSVD;
                2,3,4,5,6,7,8,9,10: t = REQ_INSERT;
                default: t = REQ_QUERY;
            endcase
            if ($urandom_range(0, 9) == 0)
                r = mk(t, $urandom, $urandom, $urandom, $urandom);
            else
                r = mk(t, near(bx, 3 * csz_x), near(0, 1500), near(bz, 3 * csz_z),
                       $urandom_range(0, 9) == 0 ? $urandom_range(0, 1048575)
                                                 : $urandom_range(0, 4000));
            queue_req(r);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_ch.valid = 1'b0; req_ch.req_type = REQ_CLEAR; req_ch.actor_id = '0;
        req_ch.pos_x = '0; req_ch.pos_y = '0; req_ch.pos_z = '0; req_ch.query_radius = '0;
        res_ch.ready = 1'b0;
        mismatches = 0; hold_off = 0; sender_pause = 1'b0;
        csz_x = 16'd2560; csz_z = 16'd2560;
        foreach (fill_cnt[i]) fill_cnt[i] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, full bucket, clamping, every request type
        queue_req(mk(REQ_QUERY, 0, 0, 0, 100));
        for (int i = 0; i < 5; i++) queue_req(mk(REQ_INSERT, 100 + i, i, 50, 0));
        queue_req(mk(REQ_INSERT, -524288, -524288, -524288, 0));
        queue_req(mk(REQ_INSERT, 524287, 524287, 524287, 1048575));
        queue_req(mk(REQ_QUERY, 100, 0, 50, 3));
        queue_req(mk(REQ_QUERY, 100, 0, 50, 1048575));
        queue_req(mk(REQ_QUERY, -524288, -524288, -524288, 0));
        queue_req(mk(REQ_QUERY, 524287, 524287, 524287, 0));
        queue_req(mk(REQ_QUERY, 524287, -524288, 0, 1048575));
        queue_req(mk(REQ_RSVD, -1, -1, -1, 1048575));
        queue_req(mk(REQ_CLEAR, 0, 0, 0, 0));
        queue_req(mk(REQ_QUERY, 100, 0, 50, 1048575));
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_off = 400;
        random_phase(20);
        wait_drained();

        // several cell sizes, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin reg_write(REG_CELL_X, 16'd0); reg_write(REG_CELL_Z, 16'd1); end
                1: begin reg_write(REG_CELL_X, 16'hFFFF); reg_write(REG_CELL_Z, 16'hFFFF); end
                2: begin reg_write(REG_CELL_X, 16'd256); reg_write(REG_CELL_Z, 16'd300); end
                default: begin
                    reg_write(REG_CELL_X, CSZ_W'($urandom_range(1, 65535)));
                    reg_write(REG_CELL_Z, CSZ_W'($urandom_range(1, 65535)));
                end
            endcase
            random_phase(40);
            // sender pauses mid-phase until every expected result is back
            if (ph == 3) begin
                repeat (300) @(posedge i_clk);
                sender_pause = 1'b1;
                @(posedge i_clk);
                while (req_ch.valid || expected_res.size() > 0)
                    @(posedge i_clk);
                sender_pause = 1'b0;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("uniform_grid_neighbor_query: match");
        else
            $display("uniform_grid_neighbor_query: mismatch");
        $finish;
    end
endmodule
